[hdl/tcsw_pkg.sv]
// Shared types and constants for the text console screen writer.
// Used by tcsw_ctrl, tcsw_dp and text_console_screen_writer; no dependencies.
package tcsw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [2:0] OP_PRINT     = 3'd0;
	localparam logic [2:0] OP_BACKSPACE = 3'd1;
	localparam logic [2:0] OP_CLEAR     = 3'd2;
	localparam logic [2:0] OP_SET_CUR   = 3'd3;
	localparam logic [2:0] OP_READ_CELL = 3'd4;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_BLANK   = 8'd32;
	localparam logic [7:0] CHAR_ERASED  = 8'd0;
	localparam logic [7:0] ATTR_DEFAULT = 8'h07;

	localparam logic [3:0] FG_RESET = 4'd7;
	localparam logic [3:0] BG_RESET = 4'd0;

	// Register index as decoded from the APB byte address
	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	localparam int CELL_W = 16;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] char_code;
		logic [6:0] col;
		logic [4:0] row;
	} cmd_word_t;

	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
		logic       ignored;
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_INIT_DRAIN,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_WALK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic load;       // latch the incoming command word
		logic exec;       // carry out the latched command
		logic walk;       // advance the screen walk by one cell
		logic read_done;  // hand the cell read to the result register
		logic drain_done; // hand the walk result to the result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic go_walk;
		logic go_read;
		logic walk_last;
		logic out_free;
	} dp_status_t;

endpackage

[hdl/tcsw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcsw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/tcsw_ctrl.sv]
// Controller state machine for the screen writer: sequences init, execute, read and walk.
// Depends on tcsw_pkg.
module tcsw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  tcsw_pkg::dp_status_t st,
	output tcsw_pkg::ctrl_cmd_t  cmd
);

	tcsw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcsw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcsw_pkg::ST_INIT: begin
				if (st.walk_last) state_d = tcsw_pkg::ST_INIT_DRAIN;
			end
			tcsw_pkg::ST_INIT_DRAIN: state_d = tcsw_pkg::ST_IDLE;
			tcsw_pkg::ST_IDLE: begin
				if (cmd_valid) state_d = tcsw_pkg::ST_EXEC;
			end
			tcsw_pkg::ST_EXEC: begin
				if (st.out_free) begin
					if (st.go_walk) state_d = tcsw_pkg::ST_WALK;
					else if (st.go_read) state_d = tcsw_pkg::ST_READ;
					else state_d = tcsw_pkg::ST_IDLE;
				end
			end
			tcsw_pkg::ST_READ: state_d = tcsw_pkg::ST_IDLE;
			tcsw_pkg::ST_WALK: begin
				if (st.walk_last) state_d = tcsw_pkg::ST_DRAIN;
			end
			tcsw_pkg::ST_DRAIN: state_d = tcsw_pkg::ST_IDLE;
			default: state_d = tcsw_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd_stall = 1'b1;
		case (state_q)
			tcsw_pkg::ST_INIT: cmd.walk = 1'b1;
			tcsw_pkg::ST_INIT_DRAIN: cmd = '0;
			tcsw_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				cmd.load  = cmd_valid;
			end
			tcsw_pkg::ST_EXEC: cmd.exec = st.out_free;
			tcsw_pkg::ST_READ: cmd.read_done = 1'b1;
			tcsw_pkg::ST_WALK: cmd.walk = 1'b1;
			tcsw_pkg::ST_DRAIN: cmd.drain_done = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

[hdl/tcsw_dp.sv]
// Datapath of the screen writer: command latch, cursor, screen walk, screen RAM, result register.
// Depends on tcsw_pkg and tcsw_ram.
module tcsw_dp #(
	parameter int COLUMNS = tcsw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcsw_pkg::ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcsw_pkg::cmd_word_t  cmd_word,
	input  logic [7:0]           attr,
	input  logic                 res_stall,
	output logic                 res_valid,
	output tcsw_pkg::res_word_t  res_word,
	input  tcsw_pkg::ctrl_cmd_t  cmd,
	output tcsw_pkg::dp_status_t st
);

	// Screen is laid out as {row, col} so the address needs no multiply
	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = ROWS * (2 ** CW);

	localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

	tcsw_pkg::cmd_word_t in_q;
	logic [CW-1:0] cur_col_q, nxt_col;
	logic [RW-1:0] cur_row_q, nxt_row;
	logic [CW-1:0] walk_col_q;
	logic [RW-1:0] walk_row_q;
	logic          walk_copy_q;
	logic [7:0]    fill_attr_q;
	logic          scrolled_q;
	logic          valid_s1;
	logic          blank_s1;
	logic [AW-1:0] addr_s1;
	logic          res_valid_q;
	tcsw_pkg::res_word_t res_q;

	logic          col_ok, row_ok, in_ok;
	logic [CW-1:0] in_col;
	logic [RW-1:0] in_row;
	logic          at_last_col, at_last_row;
	logic          ex_we, ex_scroll, ex_ignored, go_walk, go_read, walk_copy_d;
	logic [15:0]   ex_wdata;
	logic          copy_now;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_wdata, ram_rdata;
	logic          out_free;

	assign col_ok = {1'b0, in_q.col} < 8'(COLUMNS);
	assign row_ok = {1'b0, in_q.row} < 6'(ROWS);
	assign in_ok  = col_ok && row_ok;
	assign in_col = in_q.col[CW-1:0];
	assign in_row = in_q.row[RW-1:0];

	assign at_last_col = cur_col_q == COL_LAST;
	assign at_last_row = cur_row_q == ROW_LAST;

	// Decode the latched command against the current cursor
	always_comb begin
		nxt_col     = cur_col_q;
		nxt_row     = cur_row_q;
		ex_we       = 1'b0;
		ex_wdata    = {attr, in_q.char_code};
		ex_scroll   = 1'b0;
		ex_ignored  = 1'b0;
		go_walk     = 1'b0;
		go_read     = 1'b0;
		walk_copy_d = 1'b0;
		case (in_q.op)
			tcsw_pkg::OP_PRINT: begin
				ex_we = in_q.char_code != tcsw_pkg::CHAR_NEWLINE;
				if (ex_we && !at_last_col) begin
					nxt_col = cur_col_q + 1'b1;
				end else if (at_last_row) begin
					nxt_col     = '0;
					ex_scroll   = 1'b1;
					go_walk     = 1'b1;
					walk_copy_d = 1'b1;
				end else begin
					nxt_col = '0;
					nxt_row = cur_row_q + 1'b1;
				end
			end
			tcsw_pkg::OP_BACKSPACE: begin
				ex_wdata = {attr, tcsw_pkg::CHAR_ERASED};
				if (cur_col_q != '0) begin
					nxt_col = cur_col_q - 1'b1;
					ex_we   = 1'b1;
				end else if (cur_row_q != '0) begin
					nxt_col = COL_LAST;
					nxt_row = cur_row_q - 1'b1;
					ex_we   = 1'b1;
				end
			end
			tcsw_pkg::OP_CLEAR: begin
				nxt_col = '0;
				nxt_row = '0;
				go_walk = 1'b1;
			end
			tcsw_pkg::OP_SET_CUR: begin
				if (in_ok) begin
					nxt_col = in_col;
					nxt_row = in_row;
				end else begin
					ex_ignored = 1'b1;
				end
			end
			tcsw_pkg::OP_READ_CELL: begin
				go_read    = in_ok;
				ex_ignored = !in_ok;
			end
			default: ex_we = 1'b0;
		endcase
	end

	// Walk copies row r+1 into row r; the last row and clears get blanks
	assign copy_now = walk_copy_q && (walk_row_q != ROW_LAST);

	assign ram_re    = (cmd.exec && go_read) || (cmd.walk && copy_now);
	assign ram_raddr = cmd.walk ? {walk_row_q + 1'b1, walk_col_q} : {in_row, in_col};

	// Backspace writes at the new cursor, print at the old one
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {cur_row_q, cur_col_q};
		ram_wdata = ex_wdata;
		if (valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = blank_s1 ? {fill_attr_q, tcsw_pkg::CHAR_BLANK} : ram_rdata;
		end else if (cmd.exec && ex_we) begin
			ram_we = 1'b1;
			if (in_q.op == tcsw_pkg::OP_BACKSPACE) begin
				ram_waddr = {nxt_row, nxt_col};
			end
		end
	end

	tcsw_ram #(
		.WIDTH(tcsw_pkg::CELL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= cmd_word;
		end
		if (cmd.walk) begin
			addr_s1  <= {walk_row_q, walk_col_q};
			blank_s1 <= !copy_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			walk_col_q  <= '0;
			walk_row_q  <= '0;
			walk_copy_q <= 1'b0;
			fill_attr_q <= tcsw_pkg::ATTR_DEFAULT;
			scrolled_q  <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= cmd.walk;
			if (cmd.exec) begin
				cur_col_q  <= nxt_col;
				cur_row_q  <= nxt_row;
				scrolled_q <= ex_scroll;
				if (go_walk) begin
					walk_copy_q <= walk_copy_d;
					fill_attr_q <= attr;
				end
			end
			if (cmd.walk) begin
				if (walk_col_q == COL_LAST) begin
					walk_col_q <= '0;
					walk_row_q <= (walk_row_q == ROW_LAST) ? '0 : walk_row_q + 1'b1;
				end else begin
					walk_col_q <= walk_col_q + 1'b1;
				end
			end
		end
	end

	// Result register: one word held until taken
	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((cmd.exec && !go_walk && !go_read) || cmd.read_done || cmd.drain_done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !go_walk && !go_read) begin
			res_q.cursor_col <= 7'(nxt_col);
			res_q.cursor_row <= 5'(nxt_row);
			res_q.scrolled   <= 1'b0;
			res_q.ignored    <= ex_ignored;
			res_q.cell_char  <= '0;
			res_q.cell_attr  <= '0;
		end else if (cmd.read_done) begin
			res_q.cursor_col <= 7'(cur_col_q);
			res_q.cursor_row <= 5'(cur_row_q);
			res_q.scrolled   <= 1'b0;
			res_q.ignored    <= 1'b0;
			res_q.cell_char  <= ram_rdata[7:0];
			res_q.cell_attr  <= ram_rdata[15:8];
		end else if (cmd.drain_done) begin
			res_q.cursor_col <= 7'(cur_col_q);
			res_q.cursor_row <= 5'(cur_row_q);
			res_q.scrolled   <= scrolled_q;
			res_q.ignored    <= 1'b0;
			res_q.cell_char  <= '0;
			res_q.cell_attr  <= '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	assign st.go_walk   = go_walk;
	assign st.go_read   = go_read;
	assign st.walk_last = (walk_col_q == COL_LAST) && (walk_row_q == ROW_LAST);
	assign st.out_free  = out_free;

endmodule

[hdl/text_console_screen_writer.sv]
// Top level of the text console screen writer: APB color registers, controller, datapath.
// Depends on tcsw_pkg, tcsw_ctrl, tcsw_dp (which holds tcsw_ram).
//
//  channel   handshake            payload
//  cmd       cmd_valid/cmd_stall  cmd_word  (op, char_code, col, row)
//  res       res_valid/res_stall  res_word  (cursor, scrolled, ignored, cell)
//  apb       psel/penable/pready  paddr, pwdata, prdata (fg_color at 0, bg_color at 4)
//
// Print, newline, backspace, set cursor, no-op and an off-screen read finish in the execute
// state; an on-screen read cell adds the READ state for the registered RAM read. Clear and
// any scroll then walk every cell once, as one screen RAM write port serves the walk.
// After reset a clearing pass fills the screen, cmd_stall high.
// A command is taken while a finished result still waits on res_stall; it executes
// once the result register frees up.
module text_console_screen_writer #(
	parameter int COLUMNS = tcsw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcsw_pkg::ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  tcsw_pkg::cmd_word_t cmd_word,
	output logic                res_valid,
	input  logic                res_stall,
	output tcsw_pkg::res_word_t res_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [3:0] fg_color_q, bg_color_q;
	logic       reg_sel;
	logic       cfg_write;

	tcsw_pkg::ctrl_cmd_t  cmd;
	tcsw_pkg::dp_status_t st;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q <= tcsw_pkg::FG_RESET;
			bg_color_q <= tcsw_pkg::BG_RESET;
		end else if (cfg_write) begin
			if (reg_sel == tcsw_pkg::REG_FG) begin
				fg_color_q <= pwdata[3:0];
			end else begin
				bg_color_q <= pwdata[3:0];
			end
		end
	end

	assign prdata = (reg_sel == tcsw_pkg::REG_FG) ? {28'd0, fg_color_q} : {28'd0, bg_color_q};

	tcsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.st       (st),
		.cmd      (cmd)
	);

	tcsw_dp #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_word (cmd_word),
		.attr     ({bg_color_q, fg_color_q}),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res_word (res_word),
		.cmd      (cmd),
		.st       (st)
	);

endmodule
